### hw/rtl/bqf_pkg.sv
`default_nettype none

package bqf_pkg;

  // Sample and coefficient width, fixed by the interface.
  localparam int DATA_W = 32;
  // Product width of two samples or coefficients.
  localparam int PROD_W = 64;

  // Configuration register map, one 32-bit word per register.
  localparam int NUM_REGS  = 5;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = 5;

  localparam logic [REG_IDX_W-1:0] REG_FEED_COEF_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FEED_COEF_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FEED_COEF_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BACK_COEF_1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BACK_COEF_2 = 3'd4;

  // Commands to the datapath. At most one is high, or update with load_out.
  typedef struct packed {
    logic load_ff;   // capture feedforward products of the accepted sample
    logic sum;       // form the output sample
    logic mul_fb;    // capture feedback products of the output sample
    logic update;    // write both delay registers
    logic load_out;  // move the output sample into the output register
  } bqf_cmd_t;

  // One configuration write, decoded from the bus.
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } bqf_cfg_wr_t;

endpackage

`default_nettype wire

### hw/rtl/bqf_ctrl.sv
`default_nettype none

module bqf_ctrl
  import bqf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output bqf_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_MUL_FB = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_PUSH   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  // The output register can take a new sample when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_ff = 1'b1;
          state_next  = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_MUL_FB;
      end
      ST_MUL_FB: begin
        cmd.mul_fb = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bqf_datapath.sv
`default_nettype none

module bqf_datapath
  import bqf_pkg::*;
#(
  parameter int FRAC_BITS = 18
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire bqf_cmd_t                 cmd,
  input  wire bqf_cfg_wr_t              cfg_wr,
  input  wire logic [REG_IDX_W-1:0]     rd_idx,
  output logic        [DATA_W-1:0]      rd_data,
  input  wire logic signed [DATA_W-1:0] sample_in,
  output logic signed [DATA_W-1:0]      sample_out
);

  // Unity gain in Q(FRAC_BITS).
  localparam logic signed [DATA_W-1:0] COEF_ONE = DATA_W'(1) << FRAC_BITS;

  logic signed [DATA_W-1:0] feed_coef_0;
  logic signed [DATA_W-1:0] feed_coef_1;
  logic signed [DATA_W-1:0] feed_coef_2;
  logic signed [DATA_W-1:0] back_coef_1;
  logic signed [DATA_W-1:0] back_coef_2;
  logic signed [DATA_W-1:0] delay_one;
  logic signed [DATA_W-1:0] delay_two;

  logic signed [PROD_W-1:0] prod_ff0;
  logic signed [PROD_W-1:0] prod_ff1;
  logic signed [PROD_W-1:0] prod_ff2;
  logic signed [PROD_W-1:0] prod_fb1;
  logic signed [PROD_W-1:0] prod_fb2;
  logic signed [DATA_W-1:0] y_sum;

  logic signed [PROD_W-1:0] diff_one;
  logic signed [PROD_W-1:0] diff_two;
  logic signed [DATA_W-1:0] delay_one_next;
  logic signed [DATA_W-1:0] delay_two_next;
  logic signed [DATA_W-1:0] y_sum_next;
  logic                     cfg_hit;

  // Truncating the arithmetic shift to 32 bits is a plain part-select.
  assign y_sum_next     = prod_ff0[FRAC_BITS +: DATA_W] + delay_one;
  assign diff_one       = prod_ff1 - prod_fb1;
  assign diff_two       = prod_ff2 - prod_fb2;
  assign delay_one_next = diff_one[FRAC_BITS +: DATA_W] + delay_two;
  assign delay_two_next = diff_two[FRAC_BITS +: DATA_W];

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_wr.idx)
      REG_FEED_COEF_0, REG_FEED_COEF_1, REG_FEED_COEF_2,
      REG_BACK_COEF_1, REG_BACK_COEF_2: cfg_hit = cfg_wr.en;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (rd_idx)
      REG_FEED_COEF_0: rd_data = feed_coef_0;
      REG_FEED_COEF_1: rd_data = feed_coef_1;
      REG_FEED_COEF_2: rd_data = feed_coef_2;
      REG_BACK_COEF_1: rd_data = back_coef_1;
      REG_BACK_COEF_2: rd_data = back_coef_2;
      default:         rd_data = '0;
    endcase
  end

  // Coefficients and filter state. A coefficient write restarts the filter.
  always_ff @(posedge clk) begin
    if (rst) begin
      feed_coef_0 <= COEF_ONE;
      feed_coef_1 <= '0;
      feed_coef_2 <= '0;
      back_coef_1 <= '0;
      back_coef_2 <= '0;
      delay_one   <= '0;
      delay_two   <= '0;
    end else if (cfg_hit) begin
      case (cfg_wr.idx)
        REG_FEED_COEF_0: feed_coef_0 <= cfg_wr.data;
        REG_FEED_COEF_1: feed_coef_1 <= cfg_wr.data;
        REG_FEED_COEF_2: feed_coef_2 <= cfg_wr.data;
        REG_BACK_COEF_1: back_coef_1 <= cfg_wr.data;
        REG_BACK_COEF_2: back_coef_2 <= cfg_wr.data;
        default: ;
      endcase
      delay_one <= '0;
      delay_two <= '0;
    end else if (cmd.update) begin
      delay_one <= delay_one_next;
      delay_two <= delay_two_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ff) begin
      prod_ff0 <= sample_in * feed_coef_0;
      prod_ff1 <= sample_in * feed_coef_1;
      prod_ff2 <= sample_in * feed_coef_2;
    end
    if (cmd.sum) begin
      y_sum <= y_sum_next;
    end
    if (cmd.mul_fb) begin
      prod_fb1 <= back_coef_1 * y_sum;
      prod_fb2 <= back_coef_2 * y_sum;
    end
    if (cmd.load_out) begin
      sample_out <= y_sum;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fixed_point_biquad_filter.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    sample_in  (signed 32)
// output    out        out_valid / out_stall  sample_out (signed 32)
// config    in         psel/penable/pwrite    paddr, pwdata, prdata (32)
//
// For each item the accept edge captures the three feedforward products,
// then the output sum, the two feedback products and the delay update
// follow in turn. The next item waits for the chain output sum -> feedback
// multiply -> delay update, as it needs the new delay values.
// Reset is synchronous: coefficients return to unity pass-through and both
// delay registers clear. A finished sample sits in the output register, so
// the next item is taken while it waits; if the register is still full at
// the delay update, the controller holds until it drains.
`default_nettype none

module fixed_point_biquad_filter
  import bqf_pkg::*;
#(
  parameter int FRAC_BITS = 18
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [DATA_W-1:0] sample_in,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      sample_out,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  bqf_cmd_t    cmd;
  bqf_cfg_wr_t cfg_wr;
  logic        in_accept;

  // The bus never inserts wait states. Registers sit on word addresses, so
  // the two low address bits are ignored.
  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite && pready;
  assign cfg_wr.idx  = paddr[ADDR_W-1:2];
  assign cfg_wr.data = pwdata;
  assign in_accept   = in_valid && !in_stall;

  bqf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bqf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_wr     (cfg_wr),
    .rd_idx     (paddr[ADDR_W-1:2]),
    .rd_data    (prdata),
    .sample_in  (sample_in),
    .sample_out (sample_out)
  );

  // An accepted item walks through the sum, feedback and update steps in
  // consecutive cycles.
  a_item_sequence: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> cmd.sum ##1 cmd.mul_fb ##1 cmd.update)
    else $error("item did not follow the fixed step sequence");

  // The controller issues at most one datapath step per cycle, apart from
  // the output load that may ride along with the delay update.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_ff, cmd.sum, cmd.mul_fb, cmd.update}))
    else $error("more than one datapath step in a cycle");

  // A new result only appears after the delay update or a held push.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output became valid without a load");

endmodule

`default_nettype wire

### tb/fixed_point_biquad_filter_tb.sv
`timescale 1ns / 100ps

// Checks the biquad section sample by sample against a predictor kept in this
// module. Coefficients are written and read back over the register port while
// the filter is idle. Both handshake sides idle at random, except for one
// phase that runs at full rate.
module fixed_point_biquad_filter_tb;
  import bqf_pkg::*;

  localparam int FRAC_BITS      = 18;
  localparam int WATCHDOG_LIMIT = 4000;
  // Settling time after the last expected sample has come out, to cover any
  // work still in flight.
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_ITEMS    = 100;

  localparam logic signed [DATA_W-1:0] UNITY   = 1 << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'h7fff_ffff;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'h8000_0000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] sample_in;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] sample_out;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // Predictor state: the coefficients as last written and the two delay
  // registers of the transposed structure.
  logic signed [DATA_W-1:0] coefs [NUM_REGS];
  logic signed [DATA_W-1:0] state_z1;
  logic signed [DATA_W-1:0] state_z2;

  // Filter outputs predicted for accepted items, oldest first.
  logic signed [DATA_W-1:0] expected_outputs [$];
  logic signed [DATA_W-1:0] oldest_output;

  int errors = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  fixed_point_biquad_filter #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  // Full 64-bit signed product of two 32-bit operands.
  function automatic logic signed [63:0] wide_mul(input logic signed [DATA_W-1:0] a,
                                                  input logic signed [DATA_W-1:0] b);
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Advances the predicted filter by one item and queues its output. Every
  // product is scaled down by an arithmetic shift, which rounds toward minus
  // infinity, and only the low 32 bits of each sum are kept, so the output
  // and both delays wrap instead of saturating.
  function automatic void filter_step(input logic signed [DATA_W-1:0] x);
    logic signed [63:0]       acc;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] next_z1;
    acc = wide_mul(x, coefs[REG_FEED_COEF_0]) >>> FRAC_BITS;
    y = acc[DATA_W-1:0] + state_z1;
    acc = (wide_mul(x, coefs[REG_FEED_COEF_1]) - wide_mul(coefs[REG_BACK_COEF_1], y))
          >>> FRAC_BITS;
    next_z1 = acc[DATA_W-1:0] + state_z2;
    acc = (wide_mul(x, coefs[REG_FEED_COEF_2]) - wide_mul(coefs[REG_BACK_COEF_2], y))
          >>> FRAC_BITS;
    state_z2 = acc[DATA_W-1:0];
    state_z1 = next_z1;
    expected_outputs.push_back(y);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return MIN_VAL;
      1:       return MAX_VAL;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  // Mostly full-range samples, with small values, values near unity scale
  // and the extremes mixed in.
  function automatic logic signed [DATA_W-1:0] random_sample();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6:          return $urandom_range(2000) - 1000;
      7:             return pick_extreme();
      default:       return $urandom_range(1 << 21) - (1 << 20);
    endcase
  endfunction

  // Coefficients: full-range words, values within two in Q18 (the range of
  // a practical filter), and the extremes.
  function automatic logic signed [DATA_W-1:0] random_coef();
    case ($urandom_range(3))
      0:       return $urandom;
      1, 2:    return $urandom_range(1 << 20) - (1 << 19);
      default: return pick_extreme();
    endcase
  endfunction

  // Presents one item, with a random number of empty cycles ahead of it, and
  // returns at the edge that accepts it. The valid line is only lowered when
  // a gap follows, so it is never dropped and raised at the same edge.
  task automatic send_sample(input logic signed [DATA_W-1:0] x);
    while (gaps_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    filter_step(x);
  endtask

  // Stops sending and waits until every predicted output has come out, then
  // lets the filter settle so that a register access finds it idle.
  task automatic drain_filter();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register is written at the edge that
  // ends the access. A write to a mapped coefficient also clears the delays,
  // while an unmapped index changes nothing. The bus then idles before the
  // next access.
  task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < NUM_REGS) begin
      coefs[idx] = value;
      state_z1   = '0;
      state_z2   = '0;
    end
    @(posedge clk);
  endtask

  task automatic check_reg(input int idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== coefs[idx]) begin
      $error("prdata[%0d]: expected %h, actual %h", idx, coefs[idx], prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_all_regs();
    for (int i = 0; i < NUM_REGS; i++) check_reg(i);
  endtask

  // Out of reset the filter passes samples through unchanged, since the
  // leading coefficient is one and all others are zero.
  task automatic test_unity_reset();
    logic signed [DATA_W-1:0] points [5] = '{MAX_VAL, MIN_VAL, 0, 1, -1};
    check_all_regs();
    foreach (points[i]) send_sample(points[i]);
    drain_filter();
  endtask

  // Extreme coefficients against extreme samples: products reach their
  // largest size and the sums wrap.
  task automatic test_extreme_values();
    logic signed [DATA_W-1:0] points [6] = '{MIN_VAL, MAX_VAL, MIN_VAL, -1, 1, MAX_VAL};
    write_reg(REG_FEED_COEF_0, MAX_VAL);
    write_reg(REG_FEED_COEF_1, MIN_VAL);
    write_reg(REG_FEED_COEF_2, -1);
    write_reg(REG_BACK_COEF_1, MAX_VAL);
    write_reg(REG_BACK_COEF_2, MIN_VAL);
    check_all_regs();
    foreach (points[i]) send_sample(points[i]);
    drain_filter();
  endtask

  // A stable resonator builds up delay state; rewriting one coefficient with
  // its own value must still clear that state.
  task automatic test_write_clears_delays();
    write_reg(REG_FEED_COEF_0, 32'sd65536);
    write_reg(REG_FEED_COEF_1, 32'sd131072);
    write_reg(REG_FEED_COEF_2, 32'sd65536);
    write_reg(REG_BACK_COEF_1, -32'sd393216);
    write_reg(REG_BACK_COEF_2, 32'sd196608);
    repeat (3) send_sample(32'sd100000);
    drain_filter();
    write_reg(REG_FEED_COEF_1, coefs[REG_FEED_COEF_1]);
    repeat (3) send_sample(-32'sd100000);
    drain_filter();
  endtask

  // Writes to indexes past the last coefficient are dropped: the delays are
  // kept and the coefficients read back unchanged.
  task automatic test_unmapped_write_ignored();
    repeat (3) send_sample(32'sd250000);
    drain_filter();
    for (int i = NUM_REGS; i < (1 << REG_IDX_W); i++) write_reg(i, $urandom);
    check_all_regs();
    repeat (3) send_sample(-32'sd7);
    drain_filter();
  endtask

  // Phases of random samples, each with a new set of coefficients. The first
  // three phases use random, all-maximum and all-minimum settings; later ones
  // rewrite a random subset. One phase runs without any idling, and one
  // pauses midway until the filter has emptied.
  task automatic test_random_filters();
    bit wrote;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      gaps_on   = (phase != 4);
      stalls_on = (phase != 4);
      wrote     = 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        case (phase)
          0: write_reg(i, random_coef());
          1: write_reg(i, MAX_VAL);
          2: write_reg(i, MIN_VAL);
          default: begin
            if ($urandom_range(1) == 1 || (i == NUM_REGS - 1 && !wrote)) begin
              write_reg(i, random_coef());
              wrote = 1'b1;
            end
          end
        endcase
      end
      check_all_regs();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 6 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          while (expected_outputs.size() != 0) @(posedge clk);
        end
        send_sample(random_sample());
      end
      drain_filter();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Every output item that is taken is compared with the oldest prediction.
  // The stall line for the next cycle is drawn at the same edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_outputs.size() == 0) begin
        $error("sample_out: expected none, actual %h", sample_out);
        errors++;
      end else begin
        oldest_output = expected_outputs.pop_front();
        if (sample_out !== oldest_output) begin
          $error("sample_out: expected %h, actual %h", oldest_output, sample_out);
          errors++;
        end
      end
    end
    out_stall <= stalls_on && ($urandom_range(99) < 13);
  end

  // Ends the run when nothing at all has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fixed_point_biquad_filter_tb failed");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample_in = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    coefs[REG_FEED_COEF_0] = UNITY;
    coefs[REG_FEED_COEF_1] = '0;
    coefs[REG_FEED_COEF_2] = '0;
    coefs[REG_BACK_COEF_1] = '0;
    coefs[REG_BACK_COEF_2] = '0;
    state_z1 = '0;
    state_z2 = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unity_reset();
    test_extreme_values();
    test_write_clears_delays();
    test_unmapped_write_ignored();
    test_random_filters();

    drain_filter();
    if (errors == 0) begin
      $display("fixed_point_biquad_filter_tb passed");
    end else begin
      $display("fixed_point_biquad_filter_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bqf_pkg.sv
hw/rtl/bqf_ctrl.sv
hw/rtl/bqf_datapath.sv
hw/rtl/fixed_point_biquad_filter.sv
tb/fixed_point_biquad_filter_tb.sv
